/* rtl/morse_key_decoder_defines.svh */
// Assertion macros used by the checker file of the Morse key decoder.
`ifndef MORSE_KEY_DECODER_DEFINES_SVH
`define MORSE_KEY_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MKD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mkd_pkg.sv */
package mkd_pkg;

  localparam int MAX_SYMBOLS_DEF = 5;
  localparam int COUNT_WIDTH_DEF = 24;

  localparam int CNT_W     = 3;
  localparam int PAT_MAX_W = 6;
  localparam int DOT_W     = 16;
  localparam int DOT3_W    = 18;
  localparam int DOT7_W    = 19;
  localparam int FIFO_DEPTH = 4;

  localparam logic [DOT_W-1:0] DOT_TICKS_RESET     = 16'd24;
  localparam logic             PRESSED_LEVEL_RESET = 1'b1;

  localparam logic REG_DOT_TICKS     = 1'b0;
  localparam logic REG_PRESSED_LEVEL = 1'b1;

  localparam logic [7:0] ASCII_SPACE = 8'h20;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_SPACE   = 2'd1,
    KIND_UNKNOWN = 2'd2
  } kind_e;

  typedef struct packed {
    logic [6:0] char_code;
    kind_e      kind;
    logic       last;
  } res_t;

  // Bit i of the pattern is symbol i, a one is a dash.
  function automatic res_t mkd_decode(logic [PAT_MAX_W-1:0] bits, logic [CNT_W-1:0] cnt);
    logic [7:0] ch;
    logic       hit;
    res_t       res;
    ch  = 8'h00;
    hit = 1'b1;
    unique case ({cnt, bits[4:0]})
      8'b010_00010: ch = "A";
      8'b100_00001: ch = "B";
      8'b100_00101: ch = "C";
      8'b011_00001: ch = "D";
      8'b001_00000: ch = "E";
      8'b100_00100: ch = "F";
      8'b011_00011: ch = "G";
      8'b100_00000: ch = "H";
      8'b010_00000: ch = "I";
      8'b100_01110: ch = "J";
      8'b011_00101: ch = "K";
      8'b100_00010: ch = "L";
      8'b010_00011: ch = "M";
      8'b010_00001: ch = "N";
      8'b011_00111: ch = "O";
      8'b100_00110: ch = "P";
      8'b100_01011: ch = "Q";
      8'b011_00010: ch = "R";
      8'b011_00000: ch = "S";
      8'b001_00001: ch = "T";
      8'b011_00100: ch = "U";
      8'b100_01000: ch = "V";
      8'b011_00110: ch = "W";
      8'b100_01001: ch = "X";
      8'b100_01101: ch = "Y";
      8'b100_00011: ch = "Z";
      8'b101_11111: ch = "0";
      8'b101_11110: ch = "1";
      8'b101_11100: ch = "2";
      8'b101_11000: ch = "3";
      8'b101_10000: ch = "4";
      8'b101_00000: ch = "5";
      8'b101_00001: ch = "6";
      8'b101_00011: ch = "7";
      8'b101_00111: ch = "8";
      8'b101_01111: ch = "9";
      default:      hit = 1'b0;
    endcase
    if (bits[PAT_MAX_W-1]) begin
      hit = 1'b0;
    end
    res.char_code = hit ? ch[6:0] : 7'd0;
    res.kind      = hit ? KIND_CHAR : KIND_UNKNOWN;
    res.last      = 1'b0;
    return res;
  endfunction

endpackage

/* rtl/mkd_if.sv */
interface mkd_key_if;
  logic valid;
  logic ready;
  logic key_level;

  modport source (output valid, output key_level, input ready);
  modport sink (input valid, input key_level, output ready);
endinterface

interface mkd_char_if;
  logic       valid;
  logic       ready;
  logic [6:0] char_code;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output char_code, output kind, output last, input ready);
  modport sink (input valid, input char_code, input kind, input last, output ready);
endinterface

/* rtl/morse_key_decoder.sv */
// Morse key decoder.
// The key_i channel carries one sampled key level per word, one word per tick.
// The char_o channel returns decoded characters, word spaces and unknown-pattern
// flags; a tick causes zero, one or two result words, and last marks the final
// one of a tick. Every accepted key word is handled in its accept cycle against
// the held state (tick counter, pattern buffer, previous level), and its results
// are written into a four-word output queue and offered from there in order.
// key_i accepts one word every cycle while the queue has at least two free
// slots; when the receiver stalls, the queue fills and key_i.ready falls until
// char_o drains. Throughput is one key word per cycle while key_i.ready is high
// and at most one result word leaves per cycle. The APB port holds dot_ticks at
// 0x0 and pressed_level at 0x4; it should be written only while the block is
// idle. Reset empties the queue, clears the counter and pattern buffer, sets the
// previous level to released and loads dot_ticks = 24 and pressed_level = 1.
module morse_key_decoder
  import mkd_pkg::*;
#(
  parameter int MAX_SYMBOLS = MAX_SYMBOLS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mkd_key_if.sink           key_i,
  mkd_char_if.source        char_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int CMP_W   = (COUNT_WIDTH > DOT7_W) ? COUNT_WIDTH : DOT7_W;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW = FIFO_AW + 1;

  logic [DOT_W-1:0]       dot_q;
  logic [DOT3_W-1:0]      dot3_q;
  logic [DOT7_W-1:0]      dot7_q;
  logic                   pressed_q;
  logic                   cfg_wr;

  logic                   prev_q, prev_d;
  logic [COUNT_WIDTH-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic [MAX_SYMBOLS-1:0] bits_q, bits_d, bits_mid;
  logic [CNT_W-1:0]       count_q, count_d, count_mid;

  logic [CMP_W-1:0]       dur;
  logic                   full, edge_seen, release_seen, press_seen;
  logic                   ge1, ge3, ge7;
  logic                   va, vb, vc;
  res_t                   ra, rb, rc, out0, out1;
  logic [1:0]             n_res;
  logic                   accept;

  res_t                   fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_q, rd_q;
  logic [FIFO_CW-1:0]     fcnt_q;
  logic                   pop;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q     <= DOT_TICKS_RESET;
      dot3_q    <= DOT3_W'(DOT_TICKS_RESET) * DOT3_W'(3);
      dot7_q    <= DOT7_W'(DOT_TICKS_RESET) * DOT7_W'(7);
      pressed_q <= PRESSED_LEVEL_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_DOT_TICKS: begin
          dot_q  <= pwdata[DOT_W-1:0];
          dot3_q <= {1'b0, pwdata[DOT_W-1:0], 1'b0} + DOT3_W'(pwdata[DOT_W-1:0]);
          dot7_q <= {pwdata[DOT_W-1:0], 3'b000} - DOT7_W'(pwdata[DOT_W-1:0]);
        end
        REG_PRESSED_LEVEL: begin
          pressed_q <= pwdata[0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DOT_TICKS:     prdata = {16'd0, dot_q};
      REG_PRESSED_LEVEL: prdata = {31'd0, pressed_q};
    endcase
  end

  // Per-tick decode.
  assign accept = key_i.valid & key_i.ready;

  always_comb begin
    elapsed_inc  = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;
    dur          = CMP_W'(elapsed_inc);
    ge1          = dur >= CMP_W'(dot_q);
    ge3          = dur >= CMP_W'(dot3_q);
    ge7          = dur >= CMP_W'(dot7_q);

    full         = count_q >= CNT_W'(MAX_SYMBOLS);
    va           = full;
    ra           = mkd_decode(PAT_MAX_W'(bits_q), count_q);
    bits_mid     = full ? '0 : bits_q;
    count_mid    = full ? '0 : count_q;

    edge_seen    = key_i.key_level != prev_q;
    release_seen = edge_seen && (key_i.key_level != pressed_q);
    press_seen   = edge_seen && (key_i.key_level == pressed_q);

    bits_d       = bits_mid;
    count_d      = count_mid;
    rb           = mkd_decode(PAT_MAX_W'(bits_mid), count_mid);
    vb           = 1'b0;
    vc           = 1'b0;
    rc.char_code = ASCII_SPACE[6:0];
    rc.kind      = KIND_SPACE;
    rc.last      = 1'b1;

    if (release_seen && (count_mid < CNT_W'(MAX_SYMBOLS)) && ge1) begin
      for (int i = 0; i < MAX_SYMBOLS; i++) begin
        if (ge3 && (count_mid == CNT_W'(i))) begin
          bits_d[i] = 1'b1;
        end
      end
      count_d = count_mid + 1'b1;
    end

    if (press_seen && ge3) begin
      vb      = count_mid != '0;
      vc      = ge7;
      bits_d  = '0;
      count_d = '0;
    end

    n_res     = 2'(va) + 2'(vb) + 2'(vc);
    out0      = va ? ra : (vb ? rb : rc);
    out0.last = n_res == 2'd1;
    out1      = rc;

    prev_d    = key_i.key_level;
    elapsed_d = edge_seen ? '0 : elapsed_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= ~PRESSED_LEVEL_RESET;
      elapsed_q <= '0;
      bits_q    <= '0;
      count_q   <= '0;
    end else if (accept) begin
      prev_q    <= prev_d;
      elapsed_q <= elapsed_d;
      bits_q    <= bits_d;
      count_q   <= count_d;
    end
  end

  // Output queue.
  assign key_i.ready      = fcnt_q <= FIFO_CW'(FIFO_DEPTH - 2);
  assign char_o.valid     = fcnt_q != '0;
  assign char_o.char_code = fifo_mem[rd_q].char_code;
  assign char_o.kind      = fifo_mem[rd_q].kind;
  assign char_o.last      = fifo_mem[rd_q].last;
  assign pop              = char_o.valid & char_o.ready;

  always_ff @(posedge clk_i) begin
    if (accept && (n_res != 2'd0)) begin
      fifo_mem[wr_q] <= out0;
    end
    if (accept && (n_res == 2'd2)) begin
      fifo_mem[wr_q + 1'b1] <= out1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fcnt_q <= '0;
    end else begin
      if (accept) begin
        wr_q <= wr_q + FIFO_AW'(n_res);
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      fcnt_q <= fcnt_q + (accept ? FIFO_CW'(n_res) : '0) - FIFO_CW'(pop);
    end
  end

endmodule

/* rtl/mkd_checker.sv */
`include "morse_key_decoder_defines.svh"

module mkd_checker
  import mkd_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [6:0] char_code_i,
  input logic [1:0] kind_i,
  input logic       last_i
);

  `MKD_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable({char_code_i, kind_i, last_i}), "Stalled result word changed.")
  `MKD_ASSERT_NEXT(a_pair_follows, out_valid_i && out_ready_i && !last_i, out_valid_i, "Second result word of a tick is missing.")
  `MKD_ASSERT_NOW(a_space_word, out_valid_i && (kind_i == KIND_SPACE), (char_code_i == ASCII_SPACE[6:0]) && last_i, "Word space must be an ASCII space and the final word.")
  `MKD_ASSERT_NOW(a_unknown_zero, out_valid_i && (kind_i == KIND_UNKNOWN), char_code_i == 7'd0, "Unknown pattern must carry a zero code.")

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (char_o.valid),
  .out_ready_i (char_o.ready),
  .char_code_i (char_o.char_code),
  .kind_i      (char_o.kind),
  .last_i      (char_o.last)
);
